// ===== hdl/gvi_pkg.sv =====
// Package for the grid value iteration unit.
// Holds the sequencer states, mode and register codes, and the multiply unit control.
// No dependencies.
package gvi_pkg;

  localparam int MB_W = 35;
  localparam int ACC_W = 54;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_READ  = 2'd2,
    MODE_CLEAR = 2'd3
  } gvi_mode_t;

  typedef enum logic [2:0] {
    CFG_DISCOUNT  = 3'd0,
    CFG_THRESHOLD = 3'd1,
    CFG_FLOOR     = 3'd2,
    CFG_TERM_A    = 3'd3,
    CFG_TERM_B    = 3'd4,
    CFG_INTENDED  = 3'd5,
    CFG_SLIP      = 3'd6,
    CFG_SPARE     = 3'd7
  } gvi_cfg_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_READ, S_CLRV, S_CELL, S_TRD, S_TWR,
    S_RDV, S_MUL, S_DSC, S_UPD, S_SWEND
  } gvi_state_t;

  typedef struct packed {
    logic issue;
    logic clr;
  } gvi_mac_ctl_t;

endpackage

// ===== hdl/gvi_mac.sv =====
// Shared multiply-accumulate unit: registered product, then accumulate.
// Depends on gvi_pkg.
module gvi_mac (
  input  logic                               clk,
  input  logic                               rst,
  input  gvi_pkg::gvi_mac_ctl_t              ctl,
  input  logic [15:0]                        op_a,
  input  logic signed [gvi_pkg::MB_W-1:0]    op_b,
  output logic signed [gvi_pkg::ACC_W-1:0]   acc
);
  import gvi_pkg::*;

  logic signed [MB_W+16:0] prod;
  logic                    pend;
  logic                    clr_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      clr_d <= 1'b0;
    end else begin
      pend <= ctl.issue;
      clr_d <= ctl.clr;
    end
    if (ctl.issue) begin
      prod <= $signed({1'b0, op_a}) * op_b;
    end
    if (pend) begin
      acc <= (clr_d ? '0 : acc) + ACC_W'(prod);
    end
  end

endmodule

// ===== hdl/grid_value_iteration_inplace_unit.sv =====
// Top level of the in-place grid value iteration unit: sequencer, value and reward memories.
// Depends on gvi_pkg and gvi_mac.
//
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    mode, cell_index, move_dir, reward_value, sweep_limit
// out       output     out_valid/out_ready  cell_value, sweep_total, converged
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Load finishes in S_IDLE, read goes via S_READ, and clear zeroes the value memory in S_CLRV.
// A run steps ordinary cells through S_RDV, four S_MUL/S_DSC rounds and S_UPD, terminal cells
// through S_TRD and S_TWR, paced by the single shared multiplier (20 products per cell) and the
// one value memory read port. After reset a clearing pass in S_INIT holds in_ready low. The
// input is taken again while a result still waits, provided the output is being drained.
module grid_value_iteration_inplace_unit #(
  parameter int GRID_COLS = 16,
  parameter int GRID_ROWS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [7:0]         cell_index,
  input  logic [1:0]         move_dir,
  input  logic signed [31:0] reward_value,
  input  logic [15:0]        sweep_limit,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] cell_value,
  output logic [15:0]        sweep_total,
  output logic               converged,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import gvi_pkg::*;

  localparam int CELLS = GRID_ROWS * GRID_COLS;
  localparam int CA = $clog2(CELLS);
  localparam int RA = CA + 2;
  localparam int RB = $clog2(GRID_ROWS);
  localparam int CB = $clog2(GRID_COLS);

  function automatic logic signed [MB_W-1:0] rnd16(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] y;
    y = (x + ACC_W'(32768)) >>> 16;
    return y[MB_W-1:0];
  endfunction

  logic [15:0] discount, threshold, ip, sp;
  logic signed [31:0] vfloor;
  logic [7:0] term_a, term_b;

  gvi_state_t state, state_next;
  logic [2:0] cnt, cnt_next;
  logic [1:0] act, act_next;
  logic [CA-1:0] s, s_next;
  logic [RB-1:0] row, row_next;
  logic [CB-1:0] col, col_next;
  logic [RA-1:0] ic, ic_next;
  logic [15:0] k, k_next, limit, limit_next;
  logic [15:0] sweep_counter, sweep_counter_next;
  logic conv, conv_next, calm, calm_next, read_ok, read_ok_next;
  logic signed [31:0] best, best_next, own, own_next;
  logic signed [31:0] nv [4];
  logic signed [31:0] nv_next [4];

  logic out_valid_next, out_conv_next;
  logic signed [31:0] out_value_next;
  logic [15:0] out_total_next;

  logic vm_we, vm_re, rm_we, rm_re;
  logic [CA-1:0] vm_waddr, vm_raddr;
  logic [RA-1:0] rm_waddr, rm_raddr;
  logic signed [31:0] vm_wdata, rm_wdata, vm_q, rm_q;
  logic signed [31:0] vmem [CELLS];
  logic signed [31:0] rmem [4*CELLS];

  gvi_mac_ctl_t mac_ctl;
  logic [15:0] mac_a;
  logic signed [MB_W-1:0] mac_b;
  logic signed [ACC_W-1:0] acc;

  logic last_cell, is_term, finish, in_acc;
  logic [CA-1:0] nb_addr;
  logic signed [MB_W-1:0] part;
  logic signed [35:0] qs;
  logic signed [31:0] q;
  logic signed [32:0] diff, adiff;

  gvi_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .op_a (mac_a),
    .op_b (mac_b),
    .acc  (acc)
  );

  assign cfg_ready = 1'b1;
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign in_acc = in_valid && in_ready;
  assign last_cell = (s == CA'(CELLS - 1));
  assign is_term = (32'(s) == 32'(term_a)) || (32'(s) == 32'(term_b));

  always_ff @(posedge clk) begin
    if (rst) begin
      discount <= 16'd58982;
      threshold <= 16'd66;
      vfloor <= -32'sd6553600;
      term_a <= 8'd120;
      term_b <= 8'd39;
      ip <= 16'd45875;
      sp <= 16'd6554;
    end else if (cfg_valid && cfg_ready) begin
      case (gvi_cfg_t'(cfg_index))
        CFG_DISCOUNT:  discount <= cfg_data[15:0];
        CFG_THRESHOLD: threshold <= cfg_data[15:0];
        CFG_FLOOR:     vfloor <= cfg_data;
        CFG_TERM_A:    term_a <= cfg_data[7:0];
        CFG_TERM_B:    term_b <= cfg_data[7:0];
        CFG_INTENDED:  ip <= cfg_data[15:0];
        CFG_SLIP:      sp <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (vm_we) begin
      vmem[vm_waddr] <= vm_wdata;
    end
    if (vm_re) begin
      vm_q <= vmem[vm_raddr];
    end
    if (rm_we) begin
      rmem[rm_waddr] <= rm_wdata;
    end
    if (rm_re) begin
      rm_q <= rmem[rm_raddr];
    end
  end

  always_comb begin
    case (cnt[1:0])
      2'd0: nb_addr = (col == CB'(GRID_COLS - 1)) ? s : s + CA'(1);
      2'd1: nb_addr = (row == '0) ? s : s - CA'(GRID_COLS);
      2'd2: nb_addr = (col == '0) ? s : s - CA'(1);
      default: nb_addr = (row == RB'(GRID_ROWS - 1)) ? s : s + CA'(GRID_COLS);
    endcase
    if (cnt == 3'd4) begin
      nb_addr = s;
    end
  end

  always_comb begin
    part = rnd16(acc);
    qs = 36'(rm_q) + 36'(part);
    if (qs > 36'sd2147483647) begin
      q = 32'sh7fffffff;
    end else if (qs < -36'sd2147483648) begin
      q = 32'sh80000000;
    end else begin
      q = qs[31:0];
    end
    diff = 33'(own) - 33'(best);
    adiff = diff[32] ? -diff : diff;
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    act_next = act;
    s_next = s;
    row_next = row;
    col_next = col;
    ic_next = ic;
    k_next = k;
    limit_next = limit;
    sweep_counter_next = sweep_counter;
    conv_next = conv;
    calm_next = calm;
    read_ok_next = read_ok;
    best_next = best;
    own_next = own;
    nv_next = nv;
    finish = 1'b0;
    out_value_next = '0;
    vm_we = 1'b0;
    vm_waddr = s;
    vm_wdata = '0;
    vm_re = 1'b0;
    vm_raddr = nb_addr;
    rm_we = 1'b0;
    rm_waddr = ic;
    rm_wdata = '0;
    rm_re = 1'b0;
    rm_raddr = {s, act};
    mac_ctl = '0;
    mac_a = (cnt[1:0] == act) ? ip : sp;
    mac_b = MB_W'(nv[cnt[1:0]]);

    case (state)
      S_INIT: begin
        rm_we = 1'b1;
        vm_we = (ic[RA-1:CA] == '0);
        vm_waddr = ic[CA-1:0];
        ic_next = ic + RA'(1);
        if (ic == RA'(4 * CELLS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          case (gvi_mode_t'(mode))
            MODE_LOAD: begin
              rm_we = (32'(cell_index) < CELLS);
              rm_waddr = {CA'(cell_index), move_dir};
              rm_wdata = reward_value;
              finish = 1'b1;
            end
            MODE_RUN: begin
              conv_next = 1'b0;
              limit_next = sweep_limit;
              k_next = '0;
              s_next = '0;
              row_next = '0;
              col_next = '0;
              calm_next = 1'b1;
              if (sweep_limit == '0) begin
                finish = 1'b1;
              end else begin
                state_next = S_CELL;
              end
            end
            MODE_READ: begin
              vm_re = 1'b1;
              vm_raddr = CA'(cell_index);
              read_ok_next = (32'(cell_index) < CELLS);
              state_next = S_READ;
            end
            default: begin
              s_next = '0;
              state_next = S_CLRV;
            end
          endcase
        end
      end
      S_READ: begin
        finish = 1'b1;
        out_value_next = read_ok ? vm_q : '0;
        state_next = S_IDLE;
      end
      S_CLRV: begin
        vm_we = 1'b1;
        s_next = s + CA'(1);
        if (last_cell) begin
          sweep_counter_next = '0;
          finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CELL: begin
        cnt_next = '0;
        act_next = '0;
        state_next = is_term ? S_TRD : S_RDV;
      end
      S_TRD: begin
        rm_re = 1'b1;
        state_next = S_TWR;
      end
      S_TWR: begin
        vm_we = 1'b1;
        vm_wdata = rm_q;
      end
      S_RDV: begin
        vm_re = (cnt < 3'd5);
        if (cnt != 3'd0) begin
          if (cnt == 3'd5) begin
            own_next = vm_q;
          end else begin
            nv_next[cnt[1:0] - 2'd1] = vm_q;
          end
        end
        cnt_next = cnt + 3'd1;
        if (cnt == 3'd5) begin
          cnt_next = '0;
          best_next = vfloor;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        rm_re = (cnt == 3'd0);
        mac_ctl.issue = (cnt < 3'd4) || (cnt == 3'd5);
        mac_ctl.clr = (cnt == 3'd0) || (cnt == 3'd5);
        cnt_next = cnt + 3'd1;
        if (cnt == 3'd5) begin
          mac_a = discount;
          mac_b = rnd16(acc);
          cnt_next = '0;
          state_next = S_DSC;
        end
      end
      S_DSC: begin
        cnt_next = cnt + 3'd1;
        if (cnt == 3'd1) begin
          if (best < q) begin
            best_next = q;
          end
          cnt_next = '0;
          act_next = act + 2'd1;
          state_next = (act == 2'd3) ? S_UPD : S_MUL;
        end
      end
      S_UPD: begin
        vm_we = 1'b1;
        vm_wdata = best;
        if (adiff >= 33'(threshold)) begin
          calm_next = 1'b0;
        end
      end
      S_SWEND: begin
        if (calm) begin
          conv_next = 1'b1;
          finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          if (sweep_counter != 16'hffff) begin
            sweep_counter_next = sweep_counter + 16'd1;
          end
          k_next = k + 16'd1;
          s_next = '0;
          row_next = '0;
          col_next = '0;
          calm_next = 1'b1;
          if (k_next == limit) begin
            finish = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_CELL;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (state == S_TWR || state == S_UPD) begin
      if (last_cell) begin
        state_next = S_SWEND;
      end else begin
        s_next = s + CA'(1);
        state_next = S_CELL;
        if (col == CB'(GRID_COLS - 1)) begin
          col_next = '0;
          row_next = row + RB'(1);
        end else begin
          col_next = col + CB'(1);
        end
      end
    end

    out_total_next = sweep_counter_next;
    out_conv_next = conv_next;
    out_valid_next = (out_valid && !out_ready) || finish;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      ic <= '0;
      cnt <= '0;
      sweep_counter <= '0;
      conv <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      ic <= ic_next;
      cnt <= cnt_next;
      sweep_counter <= sweep_counter_next;
      conv <= conv_next;
      out_valid <= out_valid_next;
    end
    act <= act_next;
    s <= s_next;
    row <= row_next;
    col <= col_next;
    k <= k_next;
    limit <= limit_next;
    calm <= calm_next;
    read_ok <= read_ok_next;
    best <= best_next;
    own <= own_next;
    nv <= nv_next;
    if (finish) begin
      cell_value <= out_value_next;
      sweep_total <= out_total_next;
      converged <= out_conv_next;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (state == S_IDLE) && !(out_valid && !out_ready))
    else $error("input taken while the sequencer is busy or the output is full");

  a_no_collision: assert property (@(posedge clk) disable iff (rst)
    (vm_we && vm_re) |-> (vm_waddr != vm_raddr))
    else $error("value memory read and write at the same address");

  a_conv_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(conv) |-> $past(state) == S_SWEND)
    else $error("converged flag set outside the end of a sweep");

  a_mac_use: assert property (@(posedge clk) disable iff (rst)
    mac_ctl.issue |-> state == S_MUL)
    else $error("multiplier issued outside the action phase");

endmodule
